// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the dispatch table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define TCDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen outside reset
`define TCDT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: sv/tcdt_pkg.sv
// ----------------------------------------------------------------------------
// tcdt_pkg
// Shared types and constants of the timer callback dispatch table.
// ----------------------------------------------------------------------------
package tcdt_pkg;

    localparam int CHANNELS_DEF = 5;
    localparam int SLOTS_DEF    = 8;
    localparam int ID_BITS_DEF  = 4;

    // fixed port widths
    localparam int OP_W     = 2;
    localparam int SEL_W    = 3;
    localparam int CBID_W   = 4;
    localparam int KEEP_W   = 16;
    localparam int OUT_ID_W = 4;
    localparam int LEFT_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_REG  = 2'd0,
        OP_CLR  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    // decision of one dispatch step
    typedef struct packed {
        logic move;
        logic done;
        logic stop;
    } t_step_ctl;

endpackage

// File: sv/tcdt_slot_ram.sv
// ----------------------------------------------------------------------------
// tcdt_slot_ram
// Callback id store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tcdt_slot_ram #(
    parameter int DEPTH = 40,
    parameter int AW    = 6,
    parameter int DW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: sv/tcdt_step.sv
// ----------------------------------------------------------------------------
// tcdt_step
// Shared dispatch step unit: keep test, index and count update.
// ----------------------------------------------------------------------------
module tcdt_step #(
    parameter int SLOTS   = 8,
    parameter int ID_BITS = 4,
    localparam int CW     = $clog2(SLOTS + 1)
) (
    input  logic [CW-1:0]                i_idx,
    input  logic [CW-1:0]                i_cnt,
    input  logic [ID_BITS-1:0]           i_cur,
    input  logic [tcdt_pkg::KEEP_W-1:0]  i_keep,
    output tcdt_pkg::t_step_ctl          o_ctl,
    output logic [CW-1:0]                o_idx_next,
    output logic [CW-1:0]                o_cnt_next
);

    logic [5:0]    cur_w;
    logic [CW-1:0] cnt_dec;
    logic          kept;

    always_comb begin
        cur_w   = 6'(i_cur);
        // ids above the mask width always retire
        kept    = (cur_w < 6'd16) && i_keep[cur_w[3:0]];
        cnt_dec = i_cnt - CW'(1);

        o_idx_next = kept ? i_idx + CW'(1) : i_idx;
        o_cnt_next = kept ? i_cnt : cnt_dec;

        o_ctl.move = !kept && (i_idx < cnt_dec);
        o_ctl.done = o_idx_next >= o_cnt_next;
        o_ctl.stop = !kept && (cnt_dec == '0);
    end

endmodule

// File: sv/timer_callback_dispatch_table.sv
// ----------------------------------------------------------------------------
// timer_callback_dispatch_table
// Per-channel callback lists with register, clear and tick dispatch.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  request   i_operation i_timer_select i_callback_id     start & !busy
//            i_keep_mask
//  result    o_status o_invoke_valid o_invoked_id         o_valid strobe
//            o_entries_left o_timer_running o_last
//
//  register, clear, unused code and bad select: one result the cycle after
//  the request, busy stays low so a request can be taken every cycle.
//  tick: one result if the list is empty; else each invoked id passes
//  through S_READ (address), then S_EVAL (compare, last entry swap-in).
//  reset is synchronous; counts and running flags clear at once.
//  results are never stalled; each strobe lasts one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timer_callback_dispatch_table #(
    parameter int CHANNELS = tcdt_pkg::CHANNELS_DEF,
    parameter int SLOTS    = tcdt_pkg::SLOTS_DEF,
    parameter int ID_BITS  = tcdt_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tcdt_pkg::OP_W-1:0]     i_operation,
    input  logic [tcdt_pkg::SEL_W-1:0]    i_timer_select,
    input  logic [tcdt_pkg::CBID_W-1:0]   i_callback_id,
    input  logic [tcdt_pkg::KEEP_W-1:0]   i_keep_mask,
    output logic                          o_valid,
    output logic                          o_status,
    output logic                          o_invoke_valid,
    output logic [tcdt_pkg::OUT_ID_W-1:0] o_invoked_id,
    output logic [tcdt_pkg::LEFT_W-1:0]   o_entries_left,
    output logic                          o_timer_running,
    output logic                          o_last
);

    localparam int CW    = $clog2(SLOTS + 1);
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    tcdt_pkg::t_state r_state, n_state;
    logic [CHW-1:0]   r_ch, n_ch;
    logic [AW-1:0]    r_base, n_base;
    logic [tcdt_pkg::KEEP_W-1:0] r_keep, n_keep;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic [CW-1:0]    r_count [CHANNELS];
    logic             r_run   [CHANNELS];

    logic             r_valid, n_valid;
    logic             r_status, n_status;
    logic             r_inv, n_inv;
    logic [tcdt_pkg::OUT_ID_W-1:0] r_id, n_id;
    logic [tcdt_pkg::LEFT_W-1:0]   r_left, n_left;
    logic             r_running, n_running;
    logic             r_last, n_last;

    // channel table update
    logic             tbl_we;
    logic [CHW-1:0]   tbl_ch;
    logic [CW-1:0]    tbl_cnt;
    logic             tbl_run;

    // request decode
    logic [2:0]       sel_map;
    logic             ch_ok;
    logic [CHW-1:0]   req_ch;
    logic [AW-1:0]    req_base;
    logic [CW-1:0]    req_cnt;
    logic             req_run;

    // slot ram
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ID_BITS-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr_a;
    logic [AW-1:0]       ram_raddr_b;
    logic [ID_BITS-1:0]  ram_rdata_a;
    logic [ID_BITS-1:0]  ram_rdata_b;

    tcdt_pkg::t_step_ctl step_ctl;
    logic [CW-1:0]       step_idx_next;
    logic [CW-1:0]       step_cnt_next;

    tcdt_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ID_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    tcdt_step #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_step (
        .i_idx      (r_idx),
        .i_cnt      (r_cnt),
        .i_cur      (ram_rdata_a),
        .i_keep     (r_keep),
        .o_ctl      (step_ctl),
        .o_idx_next (step_idx_next),
        .o_cnt_next (step_cnt_next)
    );

    // combined selections fold onto their lower timer
    always_comb begin
        case (i_timer_select)
            3'd5:    sel_map = 3'd2;
            3'd6:    sel_map = 3'd4;
            default: sel_map = i_timer_select;
        endcase
        ch_ok    = (i_timer_select != 3'd7) && (int'(sel_map) < CHANNELS);
        req_ch   = CHW'(sel_map);
        req_base = AW'(req_ch) * SLOTS_A;
        req_cnt  = ch_ok ? r_count[req_ch] : '0;
        req_run  = ch_ok ? r_run[req_ch] : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcdt_pkg::S_IDLE;
            r_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_count[c] <= '0;
                r_run[c]   <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (tbl_we) begin
                r_count[tbl_ch] <= tbl_cnt;
                r_run[tbl_ch]   <= tbl_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch      <= n_ch;
        r_base    <= n_base;
        r_keep    <= n_keep;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_status  <= n_status;
        r_inv     <= n_inv;
        r_id      <= n_id;
        r_left    <= n_left;
        r_running <= n_running;
        r_last    <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_base    = r_base;
        n_keep    = r_keep;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_status  = 1'b0;
        n_inv     = 1'b0;
        n_id      = '0;
        n_left    = '0;
        n_running = 1'b0;
        n_last    = 1'b1;
        tbl_we    = 1'b0;
        tbl_ch    = req_ch;
        tbl_cnt   = '0;
        tbl_run   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = req_base + AW'(req_cnt);
        ram_wdata = ID_BITS'(i_callback_id);
        ram_raddr_a = r_base + AW'(r_idx);
        ram_raddr_b = r_base + AW'(r_cnt - CW'(1));

        unique case (r_state)
            tcdt_pkg::S_IDLE: begin
                if (start) begin
                    n_valid = 1'b1;
                    if (ch_ok) begin
                        unique case (i_operation)
                            tcdt_pkg::OP_REG: begin
                                if (req_cnt >= SLOTS_C) begin
                                    n_status  = 1'b1;
                                    n_left    = tcdt_pkg::LEFT_W'(req_cnt);
                                    n_running = req_run;
                                end else begin
                                    ram_we    = 1'b1;
                                    tbl_we    = 1'b1;
                                    tbl_cnt   = req_cnt + CW'(1);
                                    tbl_run   = (req_cnt == '0) ? 1'b1 : req_run;
                                    n_left    = tcdt_pkg::LEFT_W'(tbl_cnt);
                                    n_running = tbl_run;
                                end
                            end
                            tcdt_pkg::OP_CLR: begin
                                tbl_we = 1'b1;
                            end
                            tcdt_pkg::OP_TICK: begin
                                if (req_cnt == '0) begin
                                    n_running = req_run;
                                end else begin
                                    // results come from the walk instead
                                    n_valid = 1'b0;
                                    n_ch    = req_ch;
                                    n_base  = req_base;
                                    n_keep  = i_keep_mask;
                                    n_idx   = '0;
                                    n_cnt   = req_cnt;
                                    n_state = tcdt_pkg::S_READ;
                                end
                            end
                            default: begin
                                n_left    = tcdt_pkg::LEFT_W'(req_cnt);
                                n_running = req_run;
                            end
                        endcase
                    end
                end
            end
            tcdt_pkg::S_READ: begin
                n_state = tcdt_pkg::S_EVAL;
            end
            tcdt_pkg::S_EVAL: begin
                n_valid   = 1'b1;
                n_inv     = 1'b1;
                n_id      = tcdt_pkg::OUT_ID_W'(ram_rdata_a);
                n_left    = tcdt_pkg::LEFT_W'(step_cnt_next);
                n_running = r_run[r_ch] && !step_ctl.stop;
                n_last    = step_ctl.done;
                tbl_we    = 1'b1;
                tbl_ch    = r_ch;
                tbl_cnt   = step_cnt_next;
                tbl_run   = n_running;
                // last entry fills the retired slot and is read next
                ram_we    = step_ctl.move;
                ram_waddr = r_base + AW'(r_idx);
                ram_wdata = ram_rdata_b;
                n_idx     = step_idx_next;
                n_cnt     = step_cnt_next;
                n_state   = step_ctl.done ? tcdt_pkg::S_IDLE : tcdt_pkg::S_READ;
            end
            default: begin
                n_state = tcdt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != tcdt_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_invoke_valid  = r_inv;
    assign o_invoked_id    = r_id;
    assign o_entries_left  = r_left;
    assign o_timer_running = r_running;
    assign o_last          = r_last;

    `TCDT_ASSERT(a_mid_walk_busy, o_valid && !o_last |-> busy, "walk result without busy")
    `TCDT_ASSERT(a_eval_emits, r_state == tcdt_pkg::S_EVAL |=> o_valid && o_invoke_valid,
        "dispatch step gave no result")
    `TCDT_ASSERT(a_walk_bounds, busy |-> (r_cnt <= SLOTS_C) && (r_idx < r_cnt),
        "walk index or count out of range")
    `TCDT_NEVER(a_tick_status, o_valid && o_invoke_valid && o_status,
        "full status on an invoke result")

endmodule

// File: test/tb_timer_callback_dispatch_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_callback_dispatch_table
// Self-checking bench for the per-timer callback dispatch table. Requests are
// driven through the start/busy handshake, a shadow copy of the channel lists
// works out every dispatch beat, and each strobed result is compared in order.
// ----------------------------------------------------------------------------
module tb_timer_callback_dispatch_table;

    localparam int NUM_CH    = tcdt_pkg::CHANNELS_DEF;
    localparam int NUM_SLOTS = tcdt_pkg::SLOTS_DEF;

    localparam logic [tcdt_pkg::OP_W-1:0]   OP_UNUSED  = 2'd3;
    localparam logic [tcdt_pkg::SEL_W-1:0]  SEL_COMB23 = 3'd5;
    localparam logic [tcdt_pkg::SEL_W-1:0]  SEL_COMB45 = 3'd6;
    localparam logic [tcdt_pkg::SEL_W-1:0]  SEL_NONE   = 3'd7;
    localparam logic [tcdt_pkg::KEEP_W-1:0] KEEP_ALL   = 16'hFFFF;
    localparam logic [tcdt_pkg::KEEP_W-1:0] KEEP_NONE  = 16'h0000;

    typedef struct packed {
        logic                          status;
        logic                          invoke_valid;
        logic [tcdt_pkg::OUT_ID_W-1:0] invoked_id;
        logic [tcdt_pkg::LEFT_W-1:0]   entries_left;
        logic                          timer_running;
        logic                          last;
    } t_dispatch_beat;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [tcdt_pkg::OP_W-1:0]     i_operation;
    logic [tcdt_pkg::SEL_W-1:0]    i_timer_select;
    logic [tcdt_pkg::CBID_W-1:0]   i_callback_id;
    logic [tcdt_pkg::KEEP_W-1:0]   i_keep_mask;
    logic                          o_valid;
    logic                          o_status;
    logic                          o_invoke_valid;
    logic [tcdt_pkg::OUT_ID_W-1:0] o_invoked_id;
    logic [tcdt_pkg::LEFT_W-1:0]   o_entries_left;
    logic                          o_timer_running;
    logic                          o_last;

    // shadow copy of the channel lists
    logic [tcdt_pkg::CBID_W-1:0] shadow_ids [NUM_CH][NUM_SLOTS];
    int unsigned                 shadow_count [NUM_CH];
    logic                        shadow_running [NUM_CH];

    t_dispatch_beat pending_beats[$];
    int             err_count;
    int             idle_pct;

    timer_callback_dispatch_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_timer_select  (i_timer_select),
        .i_callback_id   (i_callback_id),
        .i_keep_mask     (i_keep_mask),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_invoke_valid  (o_invoke_valid),
        .o_invoked_id    (o_invoked_id),
        .o_entries_left  (o_entries_left),
        .o_timer_running (o_timer_running),
        .o_last          (o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic int channel_of(logic [tcdt_pkg::SEL_W-1:0] sel);
        int ch;
        if (sel == SEL_COMB23) begin
            ch = 2;
        end else if (sel == SEL_COMB45) begin
            ch = 4;
        end else if (sel <= 3'd4) begin
            ch = int'(sel);
        end else begin
            return -1;
        end
        return (ch < NUM_CH) ? ch : -1;
    endfunction

    function automatic t_dispatch_beat make_beat(logic status, logic vld, logic [3:0] id,
                                                 int unsigned left, logic run, logic last);
        t_dispatch_beat b;
        b.status        = status;
        b.invoke_valid  = vld;
        b.invoked_id    = id;
        b.entries_left  = tcdt_pkg::LEFT_W'(left);
        b.timer_running = run;
        b.last          = last;
        return b;
    endfunction

    // works out the beats one accepted request gives and updates the shadow lists
    function automatic void predict_dispatch(logic [tcdt_pkg::OP_W-1:0] op,
                                             logic [tcdt_pkg::SEL_W-1:0] sel,
                                             logic [tcdt_pkg::CBID_W-1:0] id,
                                             logic [tcdt_pkg::KEEP_W-1:0] keep);
        int             ch;
        int unsigned    cnt;
        int unsigned    idx;
        logic [3:0]     cur;
        logic           have_prev;
        t_dispatch_beat prev;
        ch = channel_of(sel);
        have_prev = 1'b0;
        prev = '0;
        if (ch < 0) begin
            pending_beats.push_back(make_beat(1'b0, 1'b0, 4'd0, 0, 1'b0, 1'b1));
        end else if (op == tcdt_pkg::OP_REG) begin
            if (shadow_count[ch] >= NUM_SLOTS) begin
                pending_beats.push_back(make_beat(1'b1, 1'b0, 4'd0, shadow_count[ch],
                                                  shadow_running[ch], 1'b1));
            end else begin
                shadow_ids[ch][shadow_count[ch]] = id;
                shadow_count[ch]++;
                if (shadow_count[ch] == 1) shadow_running[ch] = 1'b1;
                pending_beats.push_back(make_beat(1'b0, 1'b0, 4'd0, shadow_count[ch],
                                                  shadow_running[ch], 1'b1));
            end
        end else if (op == tcdt_pkg::OP_CLR) begin
            shadow_running[ch] = 1'b0;
            shadow_count[ch] = 0;
            pending_beats.push_back(make_beat(1'b0, 1'b0, 4'd0, 0, 1'b0, 1'b1));
        end else if (op == tcdt_pkg::OP_TICK) begin
            cnt = shadow_count[ch];
            if (cnt == 0) begin
                pending_beats.push_back(make_beat(1'b0, 1'b0, 4'd0, 0,
                                                  shadow_running[ch], 1'b1));
            end else begin
                idx = 0;
                while (idx < cnt) begin
                    cur = shadow_ids[ch][idx];
                    if (keep[cur]) begin
                        idx++;
                    end else begin
                        // retire: last entry swaps in and is invoked next
                        cnt--;
                        if (cnt == 0) shadow_running[ch] = 1'b0;
                        if (idx < cnt) shadow_ids[ch][idx] = shadow_ids[ch][cnt];
                    end
                    shadow_count[ch] = cnt;
                    if (have_prev) pending_beats.push_back(prev);
                    prev = make_beat(1'b0, 1'b1, cur, cnt, shadow_running[ch], 1'b0);
                    have_prev = 1'b1;
                end
                prev.last = 1'b1;
                pending_beats.push_back(prev);
            end
        end else begin
            pending_beats.push_back(make_beat(1'b0, 1'b0, 4'd0, shadow_count[ch],
                                              shadow_running[ch], 1'b1));
        end
    endfunction

    // one request beat, with a random lead-in gap at the current idle rate
    task automatic send_request(logic [tcdt_pkg::OP_W-1:0] op,
                                logic [tcdt_pkg::SEL_W-1:0] sel,
                                logic [tcdt_pkg::CBID_W-1:0] id,
                                logic [tcdt_pkg::KEEP_W-1:0] keep);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_operation    <= tcdt_pkg::OP_W'($urandom);
            i_timer_select <= tcdt_pkg::SEL_W'($urandom);
            i_callback_id  <= tcdt_pkg::CBID_W'($urandom);
            i_keep_mask    <= tcdt_pkg::KEEP_W'($urandom);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_operation    <= op;
        i_timer_select <= sel;
        i_callback_id  <= id;
        i_keep_mask    <= keep;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_dispatch(op, sel, id, keep);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_beats.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_dispatch_beat want;
        t_dispatch_beat got;
        if (i_rst_n && o_valid) begin
            got = {o_status, o_invoke_valid, o_invoked_id, o_entries_left,
                   o_timer_running, o_last};
            if (pending_beats.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected result beat %p", $realtime, got);
            end else begin
                want = pending_beats.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: beat mismatch expected %p actual %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    task automatic test_empty_and_ignored();
        send_request(tcdt_pkg::OP_TICK, 3'd0, 4'd0, KEEP_ALL);
        send_request(OP_UNUSED, 3'd1, 4'd9, KEEP_NONE);
        send_request(tcdt_pkg::OP_REG, SEL_NONE, 4'd5, KEEP_ALL);
        send_request(tcdt_pkg::OP_TICK, SEL_NONE, 4'd0, KEEP_NONE);
    endtask

    task automatic test_fill_and_full();
        logic [tcdt_pkg::CBID_W-1:0] fill_ids [NUM_SLOTS];
        fill_ids = '{4'd15, 4'd0, 4'd3, 4'd10, 4'd7, 4'd12, 4'd5, 4'd9};
        for (int n = 0; n < NUM_SLOTS; n++)
            send_request(tcdt_pkg::OP_REG, 3'd0, fill_ids[n], KEEP_ALL);
        // list full: status set, nothing changes
        send_request(tcdt_pkg::OP_REG, 3'd0, 4'd1, KEEP_ALL);
        send_request(OP_UNUSED, 3'd0, 4'd0, KEEP_ALL);
    endtask

    task automatic test_dispatch_masks();
        send_request(tcdt_pkg::OP_TICK, 3'd0, 4'd0, KEEP_ALL);
        send_request(tcdt_pkg::OP_TICK, 3'd0, 4'd0, 16'h5A5A);
        send_request(tcdt_pkg::OP_TICK, 3'd0, 4'd0, KEEP_NONE);
        // stopped after the list emptied
        send_request(tcdt_pkg::OP_TICK, 3'd0, 4'd0, KEEP_ALL);
    endtask

    task automatic test_combined_selects();
        send_request(tcdt_pkg::OP_REG, SEL_COMB23, 4'd6, KEEP_ALL);
        send_request(tcdt_pkg::OP_REG, SEL_COMB45, 4'd11, KEEP_ALL);
        send_request(tcdt_pkg::OP_REG, 3'd4, 4'd2, KEEP_ALL);
        send_request(tcdt_pkg::OP_TICK, SEL_COMB23, 4'd0, 16'h0040);
        send_request(tcdt_pkg::OP_CLR, SEL_COMB45, 4'd0, KEEP_NONE);
        send_request(tcdt_pkg::OP_TICK, 3'd4, 4'd0, KEEP_ALL);
        send_request(tcdt_pkg::OP_CLR, 3'd1, 4'd0, KEEP_ALL);
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 5; n++)
            send_request(tcdt_pkg::OP_REG, 3'd3, tcdt_pkg::CBID_W'($urandom), KEEP_ALL);
        send_request(tcdt_pkg::OP_TICK, 3'd3, 4'd0, tcdt_pkg::KEEP_W'($urandom));
        wait_drained();
        send_request(tcdt_pkg::OP_TICK, 3'd3, 4'd0, tcdt_pkg::KEEP_W'($urandom));
        send_request(tcdt_pkg::OP_REG, 3'd3, 4'd8, KEEP_ALL);
    endtask

    task automatic test_random_traffic(int pct, int num_items);
        int                          issued;
        int                          pick;
        logic [tcdt_pkg::OP_W-1:0]   op;
        logic [tcdt_pkg::SEL_W-1:0]  sel;
        logic [tcdt_pkg::KEEP_W-1:0] keep;
        idle_pct = pct;
        issued = 0;
        while (issued < num_items) begin
            pick = $urandom_range(99);
            sel = tcdt_pkg::SEL_W'($urandom_range(6));
            if (pick < 48) op = tcdt_pkg::OP_REG;
            else if (pick < 82) op = tcdt_pkg::OP_TICK;
            else if (pick < 90) op = tcdt_pkg::OP_CLR;
            else if (pick < 95) op = OP_UNUSED;
            else begin
                op = tcdt_pkg::OP_W'($urandom);
                sel = SEL_NONE;
            end
            case ($urandom_range(9))
                0: keep = KEEP_NONE;
                1: keep = KEEP_ALL;
                default: keep = tcdt_pkg::KEEP_W'($urandom);
            endcase
            send_request(op, sel, tcdt_pkg::CBID_W'($urandom), keep);
            issued++;
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = tcdt_pkg::OP_REG;
        i_timer_select = '0;
        i_callback_id  = '0;
        i_keep_mask    = '0;
        err_count      = 0;
        idle_pct       = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            shadow_count[c]   = 0;
            shadow_running[c] = 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++) shadow_ids[c][s] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_ignored();
        test_fill_and_full();
        test_dispatch_masks();
        test_combined_selects();
        idle_pct = 8;
        test_drain_pause();
        test_random_traffic(8, 45);
        test_random_traffic(69, 45);
        test_random_traffic(0, 45);

        wait_drained();
        err_count += pending_beats.size();
        // a tick with a full list walks every slot, so watch a bit longer
        repeat (4 * NUM_SLOTS) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: timer_callback_dispatch_table.f
+incdir+sv
sv/tcdt_pkg.sv
sv/tcdt_slot_ram.sv
sv/tcdt_step.sv
sv/timer_callback_dispatch_table.sv
test/tb_timer_callback_dispatch_table.sv
